// File: rtl/core/abd_pkg.sv
package abd_pkg;

    localparam int SLOT_W    = 8;
    localparam int BATCH_W   = 7;
    localparam int BUF_W     = 16;
    localparam int CNT_W     = 64;
    localparam int Q16_W     = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [Q16_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [Q16_W-1:0] HALF_Q16 = 17'h08000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THROTTLE_ENABLE  = 2'd0,
        REG_LOAD_THRESHOLD   = 2'd1,
        REG_SMOOTHING_FACTOR = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_index;
        logic [BATCH_W-1:0] batch_count;
        logic [BUF_W-1:0]   slot_buffer_size;
    } abd_in_t;

    typedef struct packed {
        logic [SLOT_W-1:0] out_slot;
        logic [CNT_W-1:0]  packet_number;
        logic              keep_item;
        logic              last_of_batch;
        logic              half_full_warning;
        logic [CNT_W-1:0]  dropped_total;
        logic [Q16_W-1:0]  level_now;
    } abd_out_t;

    typedef struct packed {
        logic latch_in;
        logic fetch;
        logic load_cnt;
        logic upd_level;
        logic div_init;
        logic div_step;
        logic set_mode;
        logic step_item;
        logic write_back;
    } abd_cmd_t;

    typedef struct packed {
        logic skip;
        logic throttle;
        logic div_last;
        logic item_last;
    } abd_sts_t;

endpackage

// File: rtl/core/abd_ctrl.sv
module abd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output abd_pkg::abd_cmd_t cmd,
    input  abd_pkg::abd_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_UPD,
        S_DINIT,
        S_DIV,
        S_MODE,
        S_EMIT,
        S_WB
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (sts.skip)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.fetch  = 1'b1;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.load_cnt = 1'b1;
                if (sts.throttle)
                begin
                    cmd.upd_level = 1'b1;
                    state_next    = S_DINIT;
                end
                else
                begin
                    cmd.set_mode = 1'b1;
                    state_next   = S_EMIT;
                end
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_MODE;
                end
            end
            S_MODE:
            begin
                cmd.set_mode = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.step_item  = 1'b1;
                    out_valid_next = 1'b1;
                    if (sts.item_last)
                    begin
                        state_next = S_WB;
                    end
                end
            end
            S_WB:
            begin
                cmd.write_back = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/abd_datapath.sv
module abd_datapath #(
    parameter int NUM_SLOTS = 16,
    parameter int MAX_BATCH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  abd_pkg::abd_in_t                   in_data,
    input  logic                               cfg_we,
    input  logic [abd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [abd_pkg::Q16_W-1:0]          cfg_data,
    input  abd_pkg::abd_cmd_t                  cmd,
    output abd_pkg::abd_sts_t                  sts,
    output abd_pkg::abd_out_t                  out_data
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [abd_pkg::SLOT_W:0]    NUM_SLOTS_L = (abd_pkg::SLOT_W + 1)'(NUM_SLOTS);
    localparam logic [abd_pkg::BATCH_W-1:0] MAX_B       = abd_pkg::BATCH_W'(MAX_BATCH);

    typedef enum logic [1:0] {
        MODE_KEEP_ALL,
        MODE_DROP_NTH,
        MODE_DROP_ALL,
        MODE_KEEP_NTH
    } mode_t;

    logic                        en_reg;
    logic [abd_pkg::Q16_W-1:0]   thr_reg;
    logic [abd_pkg::Q16_W-1:0]   sf_reg;
    logic [abd_pkg::Q16_W-1:0]   level_reg, level_next;
    logic [NUM_SLOTS-1:0]        valid_reg;
    logic [4:0]                  div_cnt_reg;

    logic [abd_pkg::SLOT_W-1:0]  slot_reg;
    logic [abd_pkg::BATCH_W-1:0] n_reg;
    logic [abd_pkg::BUF_W-1:0]   buf_reg;
    logic [33:0]                 prod_l_reg;
    logic [32:0]                 prod_t_reg;
    logic [2*abd_pkg::CNT_W-1:0] mem [NUM_SLOTS];
    logic [2*abd_pkg::CNT_W-1:0] rd_reg;
    logic                        rd_valid_reg;
    logic [abd_pkg::CNT_W-1:0]   pkt_reg;
    logic [abd_pkg::CNT_W-1:0]   drop_reg;
    logic [15:0]                 m_reg;
    logic [15:0]                 rem_reg;
    logic [abd_pkg::Q16_W-1:0]   q_reg;
    mode_t                       mode_reg, mode_next;
    logic [abd_pkg::BATCH_W-1:0] hc_reg;
    logic [abd_pkg::BATCH_W-1:0] idx_reg;
    abd_pkg::abd_out_t           out_reg, out_next;

    logic [IDX_W-1:0]            slot_idx;
    logic [abd_pkg::Q16_W-1:0]   cfg_sat;
    logic                        over;
    logic [17:0]                 lsum;
    logic [abd_pkg::Q16_W-1:0]   lvl_inv;
    logic [abd_pkg::Q16_W-1:0]   m17;
    logic [abd_pkg::Q16_W-1:0]   trial;
    logic                        ge;
    logic [abd_pkg::Q16_W-1:0]   diff;
    logic                        d_gt_n;
    logic                        hit;
    logic                        keep;
    logic                        warn;
    logic [abd_pkg::CNT_W-1:0]   drop_inc;

    assign slot_idx = slot_reg[IDX_W-1:0];
    assign cfg_sat  = (cfg_data > abd_pkg::ONE_Q16) ? abd_pkg::ONE_Q16 : cfg_data;

    assign over = 33'({n_reg, 16'h0000}) > prod_t_reg;
    assign lsum = 18'(prod_l_reg[33:16]) + (over ? 18'(sf_reg) : 18'd0);
    assign level_next = (lsum > 18'(abd_pkg::ONE_Q16)) ? abd_pkg::ONE_Q16
                                                       : lsum[abd_pkg::Q16_W-1:0];

    assign lvl_inv = abd_pkg::ONE_Q16 - level_reg;
    assign m17     = (level_reg < lvl_inv) ? level_reg : lvl_inv;

    assign trial = {rem_reg, q_reg[abd_pkg::Q16_W-1]};
    assign ge    = trial >= {1'b0, m_reg};
    assign diff  = trial - {1'b0, m_reg};

    assign d_gt_n = q_reg > abd_pkg::Q16_W'(n_reg);

    always_comb
    begin
        if (!en_reg || level_reg == '0)
        begin
            mode_next = MODE_KEEP_ALL;
        end
        else if (level_reg < abd_pkg::HALF_Q16)
        begin
            mode_next = d_gt_n ? MODE_KEEP_ALL : MODE_DROP_NTH;
        end
        else if (level_reg == abd_pkg::ONE_Q16 || d_gt_n)
        begin
            mode_next = MODE_DROP_ALL;
        end
        else
        begin
            mode_next = MODE_KEEP_NTH;
        end
    end

    assign hit = (hc_reg == '0);

    always_comb
    begin
        case (mode_reg)
            MODE_KEEP_ALL: keep = 1'b1;
            MODE_DROP_NTH: keep = !hit;
            MODE_DROP_ALL: keep = 1'b0;
            MODE_KEEP_NTH: keep = hit;
            default:       keep = 1'b1;
        endcase
    end

    assign warn     = !en_reg && (17'({n_reg, 1'b0}) > 17'(buf_reg));
    assign drop_inc = drop_reg + abd_pkg::CNT_W'(!keep);

    always_comb
    begin
        out_next                   = out_reg;
        out_next.out_slot          = slot_reg;
        out_next.packet_number     = pkt_reg;
        out_next.keep_item         = keep;
        out_next.last_of_batch     = sts.item_last;
        out_next.half_full_warning = warn;
        out_next.dropped_total     = drop_inc;
        out_next.level_now         = level_reg;
    end

    assign sts.skip      = (n_reg == '0) || ({1'b0, slot_reg} >= NUM_SLOTS_L);
    assign sts.throttle  = en_reg;
    assign sts.div_last  = (div_cnt_reg == 5'd16);
    assign sts.item_last = (idx_reg == n_reg - 1'b1);

    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg      <= 1'b0;
            thr_reg     <= abd_pkg::HALF_Q16;
            sf_reg      <= 17'd3277;
            level_reg   <= '0;
            valid_reg   <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    abd_pkg::REG_THROTTLE_ENABLE:  en_reg  <= cfg_data[0];
                    abd_pkg::REG_LOAD_THRESHOLD:   thr_reg <= cfg_sat;
                    abd_pkg::REG_SMOOTHING_FACTOR: sf_reg  <= cfg_sat;
                    default:                       ;
                endcase
            end
            if (cmd.upd_level)
            begin
                level_reg <= level_next;
            end
            if (cmd.write_back)
            begin
                valid_reg[slot_idx] <= 1'b1;
            end
            if (cmd.div_init)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_back)
        begin
            mem[slot_idx] <= {pkt_reg, drop_reg};
        end
        if (cmd.fetch)
        begin
            rd_reg <= mem[slot_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            slot_reg <= in_data.slot_index;
            n_reg    <= (in_data.batch_count > MAX_B) ? MAX_B : in_data.batch_count;
            buf_reg  <= in_data.slot_buffer_size;
        end
        if (cmd.fetch)
        begin
            rd_valid_reg <= valid_reg[slot_idx];
            prod_l_reg   <= 34'(level_reg) * 34'(abd_pkg::ONE_Q16 - sf_reg);
            prod_t_reg   <= 33'(thr_reg) * 33'(buf_reg);
        end
        if (cmd.load_cnt)
        begin
            pkt_reg  <= rd_valid_reg ? rd_reg[2*abd_pkg::CNT_W-1:abd_pkg::CNT_W] : '0;
            drop_reg <= rd_valid_reg ? rd_reg[abd_pkg::CNT_W-1:0] : '0;
        end
        else if (cmd.step_item)
        begin
            pkt_reg  <= pkt_reg + 1'b1;
            drop_reg <= drop_inc;
        end
        if (cmd.div_init)
        begin
            m_reg   <= m17[15:0];
            rem_reg <= '0;
            q_reg   <= abd_pkg::ONE_Q16;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? diff[15:0] : trial[15:0];
            q_reg   <= {q_reg[abd_pkg::Q16_W-2:0], ge};
        end
        if (cmd.set_mode)
        begin
            mode_reg <= mode_next;
            hc_reg   <= '0;
            idx_reg  <= '0;
        end
        else if (cmd.step_item)
        begin
            idx_reg <= idx_reg + 1'b1;
            hc_reg  <= (abd_pkg::Q16_W'(hc_reg) == q_reg - 1'b1) ? '0 : hc_reg + 1'b1;
        end
        if (cmd.step_item)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// File: rtl/core/adaptive_batch_decimator_top.sv
// Adaptive batch decimator: one input transfer announces a batch of up to MAX_BATCH
// items on a slot, and the block answers with one keep/drop verdict transfer per item,
// carrying the slot's running packet id and dropped count. Batches are handled one at a
// time; while the output side accepts them, verdicts leave at one per cycle. A throttled
// batch first passes through the 17-step restoring divider that derives the decimation
// period. Per-slot counters live in a single-port memory read at batch start and written
// back at batch end. Empty batches and slots at or above NUM_SLOTS produce no verdicts and
// free the input again. Configuration writes are always accepted.
module adaptive_batch_decimator_top #(
    parameter int NUM_SLOTS = 16,
    parameter int MAX_BATCH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  abd_pkg::abd_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output abd_pkg::abd_out_t             out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [abd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [abd_pkg::Q16_W-1:0]     cfg_data
);

    abd_pkg::abd_cmd_t cmd;
    abd_pkg::abd_sts_t sts;

    assign cfg_ready = 1'b1;

    abd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    abd_datapath #(
        .NUM_SLOTS (NUM_SLOTS),
        .MAX_BATCH (MAX_BATCH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

endmodule

// File: rtl/core/abd_checker.sv
module abd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input abd_pkg::abd_out_t out_data
);

    // one batch at a time: input closes right after a transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a batch transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled verdict changed");

    // warning only appears unthrottled, where every item is kept
    a_warn_keep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.half_full_warning |-> out_data.keep_item)
        else $error("half-full warning on a dropped item");

    // batch still in flight after a non-final verdict
    a_mid_batch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_of_batch |=> !in_ready)
        else $error("input opened before batch finished");

endmodule

bind adaptive_batch_decimator_top abd_checker u_abd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
